// File: rtl/core/swpp_pkg.sv
// ----------------------------------------------------------------------------
// swpp_pkg
// shared types and constants of the single-wire pad poll engine
// ----------------------------------------------------------------------------
package swpp_pkg;

  localparam int REQUEST_BITS      = 8;
  localparam int MAX_RESPONSE_BITS = 32;

  localparam int REQ_W   = 8;
  localparam int UNIT_W  = 10;
  localparam int TICK_W  = 12;
  localparam int LEN_W   = 6;
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_BYTE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_LEN  = 3'd4;

  // reset values
  localparam logic [REQ_W-1:0]  RST_REQUEST_BYTE   = 8'h01;
  localparam logic [UNIT_W-1:0] RST_TICKS_PER_UNIT = 10'd16;
  localparam logic [TICK_W-1:0] RST_SAMPLE_DELAY   = 12'd21;
  localparam logic [TICK_W-1:0] RST_EDGE_TIMEOUT   = 12'd30;
  localparam logic [LEN_W-1:0]  RST_RESPONSE_LEN   = 6'd32;

  typedef struct packed {
    logic command;
    logic line_level;
  } swpp_in_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [WORD_W-1:0] response_word;
  } swpp_out_t;

endpackage

// File: rtl/core/swpp_chan_if.sv
// ----------------------------------------------------------------------------
// swpp_chan_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface swpp_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/single_wire_pad_poll_engine_unit.sv
// ----------------------------------------------------------------------------
// single_wire_pad_poll_engine_unit
// one-tick-per-transaction poll engine for a single-wire open-drain pad link
// ----------------------------------------------------------------------------
// result: registered in the output register, or in the skid stage while the output is stalled
// throughput: one tick per cycle while the skid stage is empty, set by the single next-state stage
// output register plus skid stage keep input open while a result waits
// reset (rst_n low, synchronous): idle phase, registers at defaults, no result
// ----------------------------------------------------------------------------
module single_wire_pad_poll_engine_unit
  import swpp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  swpp_chan_if.sink             in_chan,
  swpp_chan_if.source           out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_TX     = 3'd1;
  localparam logic [2:0] PH_STOP   = 3'd2;
  localparam logic [2:0] PH_FALL   = 3'd3;
  localparam logic [2:0] PH_SAMPLE = 3'd4;
  localparam logic [2:0] PH_RISE   = 3'd5;

  localparam logic [LEN_W-1:0] REQ_BITS = LEN_W'(REQUEST_BITS);
  localparam logic [LEN_W:0]   MAX_LEN  = (LEN_W+1)'(MAX_RESPONSE_BITS);

  // configuration
  logic [REQ_W-1:0]  request_byte_r;
  logic [UNIT_W-1:0] ticks_per_unit_r;
  logic [TICK_W-1:0] sample_delay_r;
  logic [TICK_W-1:0] edge_timeout_r;
  logic [LEN_W-1:0]  response_len_r;

  // exchange state
  logic [2:0]        phase_r, phase_nxt;
  logic [REQ_W-1:0]  tx_shift_r, tx_shift_nxt;
  logic [LEN_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [TICK_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [WORD_W-1:0] rx_shift_r, rx_shift_nxt;

  // output register and skid stage
  logic      out_valid_r, skid_valid_r;
  swpp_out_t out_r, skid_r, res_nxt;

  logic in_fire, out_free;

  assign in_chan.ready    = !skid_valid_r;
  assign in_fire          = in_chan.valid && !skid_valid_r;
  assign out_free         = !out_valid_r || out_chan.ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      request_byte_r   <= RST_REQUEST_BYTE;
      ticks_per_unit_r <= RST_TICKS_PER_UNIT;
      sample_delay_r   <= RST_SAMPLE_DELAY;
      edge_timeout_r   <= RST_EDGE_TIMEOUT;
      response_len_r   <= RST_RESPONSE_LEN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REQUEST_BYTE:   request_byte_r   <= cfg_wdata[REQ_W-1:0];
        CFG_TICKS_PER_UNIT: ticks_per_unit_r <= cfg_wdata[UNIT_W-1:0];
        CFG_SAMPLE_DELAY:   sample_delay_r   <= cfg_wdata[TICK_W-1:0];
        CFG_EDGE_TIMEOUT:   edge_timeout_r   <= cfg_wdata[TICK_W-1:0];
        CFG_RESPONSE_LEN:   response_len_r   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // next state and result for one tick
  always_comb begin
    logic [UNIT_W-1:0] unit;
    logic [TICK_W-1:0] timeout, delay, low_len;
    logic [LEN_W:0]    limit;
    logic [2:0]        ph;
    logic [REQ_W-1:0]  tx;
    logic [LEN_W-1:0]  bc;
    logic [TICK_W-1:0] tc;
    logic [WORD_W-1:0] rx;
    logic [TICK_W:0]   tc_inc;
    logic [LEN_W-1:0]  bc_inc;
    logic              line;

    unit    = (ticks_per_unit_r == '0) ? UNIT_W'(1) : ticks_per_unit_r;
    timeout = (edge_timeout_r == '0) ? TICK_W'(1) : edge_timeout_r;
    delay   = (sample_delay_r == '0) ? TICK_W'(1) : sample_delay_r;
    limit   = (response_len_r == '0) ? (LEN_W+1)'(1) : {1'b0, response_len_r};
    if (limit > MAX_LEN) limit = MAX_LEN;
    line = in_chan.payload.line_level;

    ph = phase_r;
    tx = tx_shift_r;
    bc = bit_cnt_r;
    tc = tick_cnt_r;
    rx = rx_shift_r;
    if (ph == PH_IDLE && in_chan.payload.command) begin
      ph = PH_TX;
      tx = request_byte_r;
      bc = '0;
      tc = '0;
      rx = '0;
    end

    tc_inc  = {1'b0, tc} + (TICK_W+1)'(1);
    bc_inc  = bc + LEN_W'(1);
    low_len = tx[REQ_W-1] ? {2'b00, unit} : ({2'b00, unit} + {1'b0, unit, 1'b0});

    res_nxt               = '0;
    res_nxt.busy_res      = (ph != PH_IDLE);
    phase_nxt             = ph;
    tx_shift_nxt          = tx;
    bit_cnt_nxt           = bc;
    tick_cnt_nxt          = tc;
    rx_shift_nxt          = rx;

    case (ph)
      PH_TX: begin
        res_nxt.drive_low = (tc < low_len);
        tick_cnt_nxt      = tc_inc[TICK_W-1:0];
        if (tc_inc >= {1'b0, unit, 2'b00}) begin
          tick_cnt_nxt = '0;
          tx_shift_nxt = {tx[REQ_W-2:0], 1'b0};
          bit_cnt_nxt  = bc_inc;
          if (bc_inc >= REQ_BITS) begin
            bit_cnt_nxt = '0;
            phase_nxt   = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        res_nxt.drive_low = 1'b1;
        tick_cnt_nxt      = tc_inc[TICK_W-1:0];
        if (tc_inc >= {3'b000, unit}) begin
          tick_cnt_nxt = '0;
          phase_nxt    = PH_FALL;
        end
      end
      PH_FALL, PH_RISE: begin
        if (line == (ph == PH_RISE)) begin
          tick_cnt_nxt = '0;
          phase_nxt    = (ph == PH_FALL) ? PH_SAMPLE : PH_FALL;
        end else begin
          tick_cnt_nxt = tc_inc[TICK_W-1:0];
          if (tc_inc >= {1'b0, timeout}) begin
            res_nxt.done_res      = 1'b1;
            res_nxt.timed_out     = 1'b1;
            res_nxt.response_word = '1;
            phase_nxt             = PH_IDLE;
            tick_cnt_nxt          = '0;
          end
        end
      end
      PH_SAMPLE: begin
        tick_cnt_nxt = tc_inc[TICK_W-1:0];
        if (tc_inc >= {1'b0, delay}) begin
          tick_cnt_nxt = '0;
          rx_shift_nxt = {rx[WORD_W-2:0], line};
          bit_cnt_nxt  = bc_inc;
          if ({1'b0, bc_inc} >= limit) begin
            res_nxt.done_res      = 1'b1;
            res_nxt.response_word = {rx[WORD_W-2:0], line};
            phase_nxt             = PH_IDLE;
          end else begin
            phase_nxt = PH_RISE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tx_shift_r <= '0;
      bit_cnt_r  <= '0;
      tick_cnt_r <= '0;
      rx_shift_r <= '0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      tx_shift_r <= tx_shift_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      rx_shift_r <= rx_shift_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_r <= in_fire;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) out_r <= skid_r;
    end else if (out_free) begin
      if (in_fire) out_r <= res_nxt;
    end else if (in_fire) begin
      skid_r <= res_nxt;
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a transaction while output register is empty");

  a_done_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_res) |-> out_r.busy_res)
    else $error("exchange end reported outside an exchange");

  a_timeout_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.timed_out) |-> (out_r.done_res && out_r.response_word == '1))
    else $error("timeout without all-ones response");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_IDLE && !in_chan.payload.command) |=> (phase_r == PH_IDLE))
    else $error("exchange began without a start tick");

endmodule

// File: tb/sv/single_wire_pad_poll_engine_unit_test.sv
// ----------------------------------------------------------------------------
// single_wire_pad_poll_engine_unit_test
// self-checking bench for the single-wire pad poll engine: every tick is
// predicted in lock step with the stimulus, line levels follow the link
// protocol so polls reach their response bits, and both channels stall at
// random while the configuration is swept between runs of ticks
// ----------------------------------------------------------------------------
module single_wire_pad_poll_engine_unit_test;
  import swpp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;

  typedef enum logic [2:0] {
    LINK_IDLE, LINK_TX, LINK_STOP, LINK_FALL, LINK_SAMPLE, LINK_RISE
  } link_phase_t;

  typedef enum int {LINE_ANY, LINE_CLEAN, LINE_NOISY, LINE_STUCK} line_style_t;

  typedef struct {
    swpp_in_t  stim;
    swpp_out_t want;
  } tick_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  hold_rx = 1'b0;

  swpp_chan_if #(.payload_t(swpp_in_t))  in_if ();
  swpp_chan_if #(.payload_t(swpp_out_t)) out_if ();

  single_wire_pad_poll_engine_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // link predictor state and its copy of the registers
  logic [REQ_W-1:0]  req_m   = RST_REQUEST_BYTE;
  logic [UNIT_W-1:0] unit_m  = RST_TICKS_PER_UNIT;
  logic [TICK_W-1:0] delay_m = RST_SAMPLE_DELAY;
  logic [TICK_W-1:0] tmo_m   = RST_EDGE_TIMEOUT;
  logic [LEN_W-1:0]  len_m   = RST_RESPONSE_LEN;

  link_phase_t       link_phase = LINK_IDLE;
  logic [7:0]        link_tx    = '0;
  int unsigned       link_bits  = 0;
  int unsigned       link_ticks = 0;
  logic [WORD_W-1:0] link_rx    = '0;

  // line behaviour of the poll in progress
  line_style_t style_now  = LINE_CLEAN;
  int unsigned stuck_at   = 0;
  bit          stuck_rise = 1'b0;

  tick_item_t tick_q [$];
  swpp_out_t  result_q [$];

  int items_made   = 0;
  int ticks_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int polls_done   = 0;
  int polls_tmo    = 0;
  int settings_cnt = 0;

  int unsigned calm_left [2] = '{0, 0};
  bit          calm_on [2]   = '{1'b0, 1'b0};

  function automatic swpp_out_t link_step(input logic start, input logic line);
    swpp_out_t   r;
    int unsigned unit, tmo, dly, lim, low_len;
    logic        want;
    r    = '0;
    unit = (unit_m == 0) ? 1 : unit_m;
    tmo  = (tmo_m == 0) ? 1 : tmo_m;
    dly  = (delay_m == 0) ? 1 : delay_m;
    lim  = (len_m == 0) ? 1 : len_m;
    if (lim > MAX_RESPONSE_BITS) lim = MAX_RESPONSE_BITS;
    if (link_phase == LINK_IDLE && start) begin
      link_phase = LINK_TX;
      link_tx    = req_m;
      link_bits  = 0;
      link_ticks = 0;
      link_rx    = '0;
    end
    r.busy_res = (link_phase != LINK_IDLE);
    case (link_phase)
      LINK_TX: begin
        low_len     = link_tx[7] ? unit : 3 * unit;
        r.drive_low = (link_ticks < low_len);
        link_ticks++;
        if (link_ticks >= 4 * unit) begin
          link_ticks = 0;
          link_tx    = link_tx << 1;
          link_bits++;
          if (link_bits >= REQUEST_BITS) begin
            link_bits  = 0;
            link_phase = LINK_STOP;
          end
        end
      end
      LINK_STOP: begin
        r.drive_low = 1'b1;
        link_ticks++;
        if (link_ticks >= unit) begin
          link_ticks = 0;
          link_phase = LINK_FALL;
        end
      end
      LINK_FALL, LINK_RISE: begin
        want = (link_phase == LINK_RISE);
        if (line == want) begin
          link_ticks = 0;
          link_phase = (link_phase == LINK_FALL) ? LINK_SAMPLE : LINK_FALL;
        end else begin
          link_ticks++;
          if (link_ticks >= tmo) begin
            r.done_res      = 1'b1;
            r.timed_out     = 1'b1;
            r.response_word = '1;
            link_phase      = LINK_IDLE;
            link_ticks      = 0;
          end
        end
      end
      LINK_SAMPLE: begin
        link_ticks++;
        if (link_ticks >= dly) begin
          link_ticks = 0;
          link_rx    = {link_rx[WORD_W-2:0], line};
          link_bits++;
          if (link_bits >= lim) begin
            r.done_res      = 1'b1;
            r.response_word = link_rx;
            link_phase      = LINK_IDLE;
          end else begin
            link_phase = LINK_RISE;
          end
        end
      end
      default: ;
    endcase
    link_ticks = link_ticks & 32'hFFF;
    return r;
  endfunction

  function automatic int unsigned pick_gap(input int side);
    int unsigned roll;
    if (calm_left[side] == 0) begin
      calm_left[side] = $urandom_range(20, 200);
      calm_on[side]   = ($urandom_range(0, 3) == 0);
    end
    calm_left[side]--;
    if (calm_on[side]) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_tick(input logic start, input logic line);
    tick_item_t it;
    it.stim.command    = start;
    it.stim.line_level = line;
    it.want            = link_step(start, line);
    tick_q.push_back(it);
    items_made++;
  endtask

  // random ticks, then plain ticks until the poll in progress has ended
  task automatic fill_ticks(input int n, input line_style_t style_req);
    int          made;
    int unsigned tmo, lim, roll;
    logic        start, line, want;
    made = 0;
    tmo  = (tmo_m == 0) ? 1 : tmo_m;
    lim  = (len_m == 0) ? 1 : len_m;
    if (lim > MAX_RESPONSE_BITS) lim = MAX_RESPONSE_BITS;
    while (made < n || link_phase != LINK_IDLE) begin
      if (link_phase == LINK_IDLE) begin
        start = (made < n) && (made == 0 || $urandom_range(0, 5) == 0);
        if (start) begin
          style_now = style_req;
          if (style_req == LINE_ANY) begin
            roll      = $urandom_range(0, 9);
            style_now = (roll < 8) ? LINE_CLEAN : (roll == 8) ? LINE_NOISY : LINE_STUCK;
          end
          stuck_at   = $urandom_range(0, lim - 1);
          stuck_rise = 1'($urandom_range(0, 1));
        end
      end else begin
        start = ($urandom_range(0, 7) == 0);
      end
      line = 1'($urandom_range(0, 1));
      if (link_phase == LINK_FALL || link_phase == LINK_RISE) begin
        want = (link_phase == LINK_RISE);
        if (style_now == LINE_STUCK && link_bits >= stuck_at &&
            stuck_rise == (link_phase == LINK_RISE)) begin
          line = !want;
        end else if (style_now != LINE_NOISY) begin
          if (link_ticks + 1 >= tmo || $urandom_range(0, 3) != 0) line = want;
          else line = !want;
        end
      end
      queue_tick(start, line);
      made++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic apply_setting(input logic [REQ_W-1:0] req, input logic [UNIT_W-1:0] unit,
                               input logic [TICK_W-1:0] dly, input logic [TICK_W-1:0] tmo,
                               input logic [LEN_W-1:0] len);
    while (results_seen < items_made) @(posedge clk);
    write_reg(CFG_REQUEST_BYTE, CFG_DATA_W'(req));
    write_reg(CFG_TICKS_PER_UNIT, CFG_DATA_W'(unit));
    write_reg(CFG_SAMPLE_DELAY, CFG_DATA_W'(dly));
    write_reg(CFG_EDGE_TIMEOUT, CFG_DATA_W'(tmo));
    write_reg(CFG_RESPONSE_LEN, CFG_DATA_W'(len));
    @(posedge clk);
    cfg_we  <= 1'b0;
    req_m   = req;
    unit_m  = unit;
    delay_m = dly;
    tmo_m   = tmo;
    len_m   = len;
    settings_cnt++;
  endtask

  // input driver
  always @(posedge clk) begin : tick_driver
    int unsigned gap_left;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        result_q.push_back(tick_q[0].want);
        void'(tick_q.pop_front());
        ticks_sent++;
        gap_left = pick_gap(0);
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          in_if.valid   <= 1'b1;
          in_if.payload <= tick_q[0].stim;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    swpp_out_t   got, want;
    int unsigned stall_left;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        results_seen++;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected: word %08h",
                     results_seen, got.response_word);
        end else begin
          want = result_q.pop_front();
          if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
              got.done_res !== want.done_res || got.timed_out !== want.timed_out ||
              got.response_word !== want.response_word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at result %0d: expected drive %b busy %b done %b tmo %b word %08h",
                       results_seen, want.drive_low, want.busy_res, want.done_res,
                       want.timed_out, want.response_word);
              $display("  actual drive %b busy %b done %b tmo %b word %08h",
                       got.drive_low, got.busy_res, got.done_res, got.timed_out,
                       got.response_word);
            end
          end
          if (want.done_res) polls_done++;
          if (want.timed_out) polls_tmo++;
        end
      end
      if (hold_rx) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap(1);
      end
    end
  end

  // long receiver hold-off so the engine backs up onto its input
  initial begin
    wait (ticks_sent >= 150);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #100ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned roll;
    logic [LEN_W-1:0] len;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_REQUEST_BYTE;
    cfg_wdata      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: plain ticks at both line levels, a start, starts while busy,
    // one response bit and then a stuck line until the edge wait gives up
    style_now  = LINE_STUCK;
    stuck_at   = 1;
    stuck_rise = 1'b0;
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b0, 1'b1);
    queue_tick(1'b0, 1'b1);
    queue_tick(1'b0, 1'b0);
    for (int i = 0; i < 16; i++) queue_tick(1'b1, i[0]);
    fill_ticks(0, LINE_ANY);

    // minima, then zero registers which behave as one
    apply_setting(8'hFF, 10'd1, 12'd1, 12'd1, 6'd1);
    fill_ticks(60, LINE_ANY);
    apply_setting(8'h00, 10'd0, 12'd0, 12'd0, 6'd0);
    fill_ticks(40, LINE_ANY);

    for (int p = 0; p < 2; p++) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) len = 6'd0;
      else if (roll == 1) len = LEN_W'($urandom_range(33, 63));
      else if (roll < 4) len = 6'd32;
      else len = LEN_W'($urandom_range(1, 31));
      apply_setting(REQ_W'($urandom_range(0, 255)), UNIT_W'($urandom_range(1, 4)),
                    TICK_W'($urandom_range(1, 5)), TICK_W'($urandom_range(1, 8)), len);
      fill_ticks(1, LINE_ANY);
    end

    // response length beyond the word saturates
    apply_setting(REQ_W'($urandom_range(0, 255)), 10'd1, 12'd1, 12'd4, 6'd63);
    fill_ticks(1, LINE_ANY);

    // longer sample delay and edge timeout
    apply_setting(8'h5A, 10'd1, 12'd40, 12'd64, 6'd2);
    fill_ticks(1, LINE_STUCK);

    while (results_seen < items_made) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (result_q.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", result_q.size());
    end
    $display("ran %0d ticks over %0d register settings with random stalls on both sides",
             ticks_sent, settings_cnt + 1);
    $display("%0d polls finished, %0d of them by edge timeout, %0d mismatches",
             polls_done, polls_tmo, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
